// ----- hw/rtl/qgmq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgmq_pkg
// Types and fixed constants shared by the quota-gated message queue.
// ----------------------------------------------------------------------------
package qgmq_pkg;

  localparam int SRC_BITS    = 5;
  localparam int TOPIC_BITS  = 2;
  localparam int LEN_BITS    = 9;
  localparam int HANDLE_BITS = 32;
  localparam int BUDGET_BITS = 16;
  localparam int FILL_BITS   = 7;

  localparam logic [LEN_BITS-1:0]    PAYLOAD_CAP  = 9'd256;
  localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 16'd8192;

  localparam logic [1:0] CMD_SUBSCRIBE = 2'd0;
  localparam logic [1:0] CMD_PUBLISH   = 2'd1;
  localparam logic [1:0] CMD_POP       = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [SRC_BITS-1:0]    source_id;
    logic [TOPIC_BITS-1:0]  topic_id;
    logic [LEN_BITS-1:0]    msg_len;
    logic [HANDLE_BITS-1:0] payload_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [SRC_BITS-1:0]    out_source;
    logic [TOPIC_BITS-1:0]  out_topic;
    logic [LEN_BITS-1:0]    out_len;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [FILL_BITS-1:0]   fill_level;
  } rsp_t;

  typedef struct packed {
    logic [SRC_BITS-1:0]    src;
    logic [TOPIC_BITS-1:0]  topic;
    logic [LEN_BITS-1:0]    len;
    logic [HANDLE_BITS-1:0] handle;
  } env_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    status_t status;
    logic    sub;
    logic    push;
    logic    pop;
  } verdict_t;

endpackage

// ----- hw/rtl/qgmq_src_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgmq_src_table
// Per-source topic masks and byte totals, plus the admission decision.
// ----------------------------------------------------------------------------
module qgmq_src_table #(
  parameter int NUM_SOURCES = 32,
  parameter int NUM_TOPICS  = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  qgmq_pkg::req_t                       req,
  input  logic [qgmq_pkg::BUDGET_BITS-1:0]     byte_budget,
  input  logic [qgmq_pkg::LEN_BITS-1:0]        max_len,
  input  qgmq_pkg::qstat_t                     qstat,
  output qgmq_pkg::verdict_t                   verdict
);
  import qgmq_pkg::*;

  localparam int SIDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int TIDX_W = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;

  logic [NUM_TOPICS-1:0]  mask_r  [NUM_SOURCES];
  logic [BUDGET_BITS-1:0] bytes_r [NUM_SOURCES];

  logic [SIDX_W-1:0]      sidx;
  logic [TIDX_W-1:0]      tidx;
  logic                   ids_ok;
  logic [NUM_TOPICS-1:0]  mask_sel;
  logic [BUDGET_BITS-1:0] bytes_sel;
  logic                   topic_bit;
  logic [LEN_BITS-1:0]    limit;
  logic [BUDGET_BITS:0]   sum;
  logic                   over_budget;

  assign sidx   = SIDX_W'(req.source_id);
  assign tidx   = TIDX_W'(req.topic_id);
  assign ids_ok = (32'(req.source_id) < 32'(NUM_SOURCES)) &&
                  (32'(req.topic_id) < 32'(NUM_TOPICS));

  always_comb begin
    mask_sel  = '0;
    bytes_sel = '0;
    topic_bit = 1'b0;
    if (ids_ok) begin
      mask_sel  = mask_r[sidx];
      bytes_sel = bytes_r[sidx];
      topic_bit = mask_sel[tidx];
    end
  end

  assign limit       = (max_len < PAYLOAD_CAP) ? max_len : PAYLOAD_CAP;
  assign sum         = {1'b0, bytes_sel} + (BUDGET_BITS+1)'(req.msg_len);
  assign over_budget = sum > {1'b0, byte_budget};

  always_comb begin
    verdict = '{status: ST_REJECT, sub: 1'b0, push: 1'b0, pop: 1'b0};
    case (req.cmd)
      CMD_SUBSCRIBE: begin
        if (ids_ok) begin
          verdict.status = ST_OK;
          verdict.sub    = 1'b1;
        end
      end
      CMD_PUBLISH: begin
        if (ids_ok && (req.msg_len <= limit) && topic_bit && !over_budget &&
            !qstat.full) begin
          verdict.status = ST_OK;
          verdict.push   = 1'b1;
        end
      end
      CMD_POP: begin
        if (qstat.empty) begin
          verdict.status = ST_EMPTY;
        end else begin
          verdict.status = ST_OK;
          verdict.pop    = 1'b1;
        end
      end
      default: begin
        verdict.status = ST_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        mask_r[i]  <= '0;
        bytes_r[i] <= '0;
      end
    end else if (accept) begin
      if (verdict.sub) begin
        mask_r[sidx][tidx] <= 1'b1;
      end
      if (verdict.push) begin
        bytes_r[sidx] <= sum[BUDGET_BITS-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/qgmq_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgmq_queue
// Circular envelope store with read and write pointers and an entry count.
// ----------------------------------------------------------------------------
module qgmq_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  logic                                      pop,
  input  qgmq_pkg::env_t                            env_in,
  output qgmq_pkg::env_t                            env_out,
  output qgmq_pkg::qstat_t                          qstat,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]          count
);
  import qgmq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH-1);

  env_t             mem [QUEUE_DEPTH];
  env_t             rd_data_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign qstat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign count       = count_r;
  assign env_out     = rd_data_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end else if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage: write on push, registered read of the oldest slot on pop
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= env_in;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule

// ----- hw/rtl/quota_gated_message_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quota_gated_message_queue
// Mailbox FIFO with per-source topic subscriptions and byte quotas.
// ----------------------------------------------------------------------------
// Result strobe: registered, it rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, since every request
//   resolves against the source table and the queue in the cycle it enters.
// Reset (synchronous, rst_n low): clear topic masks, byte totals, queue
//   pointers and count at once; registers return to budget 8192, length 256.
// Results cannot be stalled: each one is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module quota_gated_message_queue #(
  parameter int NUM_SOURCES = 32,
  parameter int QUEUE_DEPTH = 64,
  parameter int NUM_TOPICS  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel
  input  logic                start,
  output logic                busy,
  input  qgmq_pkg::req_t      in_req,
  // Result channel
  output logic                out_valid,
  output qgmq_pkg::rsp_t      out_result,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import qgmq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  // Register map: byte_budget at 0x0, max_message_len at 0x4
  localparam logic REG_BUDGET = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  logic                   accept;
  logic                   cfg_wr;
  logic [BUDGET_BITS-1:0] budget_r;
  logic [LEN_BITS-1:0]    max_len_r;

  verdict_t               verdict;
  qstat_t                 qstat;
  env_t                   env_in;
  env_t                   env_out;
  logic [CNT_W-1:0]       count;

  logic                   out_valid_r;
  status_t                status_r;
  logic                   pop_ok_r;

  // The request side never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r  <= BUDGET_RESET;
      max_len_r <= PAYLOAD_CAP;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BUDGET: budget_r  <= pwdata[BUDGET_BITS-1:0];
        REG_MAXLEN: max_len_r <= pwdata[LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BUDGET: prdata = 32'(budget_r);
      REG_MAXLEN: prdata = 32'(max_len_r);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Admission: subscriptions, quotas and the per-request verdict
  // --------------------------------------------------------------------------
  qgmq_src_table #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_TOPICS  (NUM_TOPICS)
  ) u_src_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req         (in_req),
    .byte_budget (budget_r),
    .max_len     (max_len_r),
    .qstat       (qstat),
    .verdict     (verdict)
  );

  // --------------------------------------------------------------------------
  // Envelope queue: push admitted publishes, pop the oldest on request
  // --------------------------------------------------------------------------
  assign env_in = '{src:    in_req.source_id,
                    topic:  in_req.topic_id,
                    len:    in_req.msg_len,
                    handle: in_req.payload_handle};

  qgmq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept && verdict.push),
    .pop     (accept && verdict.pop),
    .env_in  (env_in),
    .env_out (env_out),
    .qstat   (qstat),
    .count   (count)
  );

  // --------------------------------------------------------------------------
  // Result register: strobe for one cycle after each request
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pop_ok_r    <= 1'b0;
    end else begin
      out_valid_r <= accept;
      pop_ok_r    <= accept && verdict.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= verdict.status;
    end
  end

  assign out_valid = out_valid_r;

  // Count and popped slot are already updated at the edge that took the
  // request, so read them directly during the result cycle.
  always_comb begin
    out_result            = '0;
    out_result.status     = status_r;
    out_result.fill_level = FILL_BITS'(count);
    if (pop_ok_r) begin
      out_result.out_source = env_out.src;
      out_result.out_topic  = env_out.topic;
      out_result.out_len    = env_out.len;
      out_result.out_handle = env_out.handle;
    end
  end

endmodule
